/* rtl/sync_search_frame_decoder_top_assert.svh */
// assertion macros used by the frame decoder datapath module
`ifndef SYNC_SEARCH_FRAME_DECODER_TOP_ASSERT_SVH
`define SYNC_SEARCH_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SSFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SSFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssfd_pkg.sv */
// shared constants, types and helpers of the sync search frame decoder
package ssfd_pkg;

    localparam int FRAME_BYTES_DEF = 24;
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [31:0] MIN_ADVANCE_RST = 32'd200;
    localparam int SYNC_LEN = 4;
    localparam int RUN_W = $clog2(SYNC_LEN);

    // decoded field offsets within the rotated frame
    localparam int FIELD_FIRST = 5;
    localparam int FIELD_BYTES = 19;
    localparam int FIELD_W = FIELD_BYTES * 8;
    localparam int OFS_FLAGS_A = 5;
    localparam int OFS_VELOCITY = 6;
    localparam int OFS_CURRENT = 8;
    localparam int OFS_SYSTEM = 12;
    localparam int OFS_FLAGS_B = 16;
    localparam int OFS_COUNTER = 17;
    localparam int OFS_FIRST = 20;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_EXTRACT,
        ST_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic wr_byte;
        logic scan_clear;
        logic rd_step;
        logic scan_eval;
        logic field_shift;
        logic out_load;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic fill_last;
        logic hit;
        logic out_free;
    } t_status;

    // bit i goes to bit 7-i
    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[7 - i] = v[i];
        end
        return r;
    endfunction

endpackage

/* rtl/ssfd_if.sv */
// valid/ready channel interfaces for received bytes and decoded frames
interface ssfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ssfd_out_if;
    logic               valid;
    logic               ready;
    logic               sync_found;
    logic [7:0]         frame_flags_a;
    logic signed [15:0] velocity;
    logic signed [31:0] current_coord;
    logic signed [31:0] system_coord;
    logic [7:0]         frame_flags_b;
    logic [23:0]        frame_counter;
    logic signed [31:0] first_frame_coord;
    logic               position_advanced;
    logic               source_active;

    modport source (
        output valid, output sync_found, output frame_flags_a, output velocity,
        output current_coord, output system_coord, output frame_flags_b,
        output frame_counter, output first_frame_coord, output position_advanced,
        output source_active, input ready
    );
    modport sink (
        input valid, input sync_found, input frame_flags_a, input velocity,
        input current_coord, input system_coord, input frame_flags_b,
        input frame_counter, input first_frame_coord, input position_advanced,
        input source_active, output ready
    );
endinterface

/* rtl/ssfd_ctrl.sv */
// controller: byte collection, sync scan, field extraction and result hand-off
module ssfd_ctrl #(
    parameter int FRAME_BYTES = ssfd_pkg::FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ssfd_pkg::t_status i_status,
    output ssfd_pkg::t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(FRAME_BYTES + ssfd_pkg::SYNC_LEN);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(FRAME_BYTES + ssfd_pkg::SYNC_LEN - 2);
    localparam logic [CNT_W-1:0] EXT_LAST = CNT_W'(ssfd_pkg::FIELD_BYTES - 1);

    ssfd_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssfd_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ssfd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.wr_byte = 1'b1;
                    if (i_status.fill_last) begin
                        o_cmd.scan_clear = 1'b1;
                        n_state = ssfd_pkg::ST_PRIME;
                    end
                end
            end
            ssfd_pkg::ST_PRIME: begin
                // first window read in flight
                o_cmd.rd_step = 1'b1;
                n_cnt = '0;
                n_state = ssfd_pkg::ST_SCAN;
            end
            ssfd_pkg::ST_SCAN: begin
                o_cmd.rd_step   = 1'b1;
                o_cmd.scan_eval = 1'b1;
                if (i_status.hit) begin
                    n_cnt = '0;
                    n_state = ssfd_pkg::ST_EXTRACT;
                end else if (r_cnt == SCAN_LAST) begin
                    n_state = ssfd_pkg::ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ssfd_pkg::ST_EXTRACT: begin
                o_cmd.rd_step     = 1'b1;
                o_cmd.field_shift = 1'b1;
                if (r_cnt == EXT_LAST) begin
                    n_state = ssfd_pkg::ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ssfd_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ssfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssfd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ssfd_dp.sv */
// datapath: byte window memory, sync run detector, field shifter, result register
`include "sync_search_frame_decoder_top_assert.svh"

module ssfd_dp #(
    parameter int FRAME_BYTES = ssfd_pkg::FRAME_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssfd_pkg::t_cmd     i_cmd,
    output ssfd_pkg::t_status  o_status,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_sync_found,
    output logic [7:0]         o_frame_flags_a,
    output logic signed [15:0] o_velocity,
    output logic signed [31:0] o_current_coord,
    output logic signed [31:0] o_system_coord,
    output logic [7:0]         o_frame_flags_b,
    output logic [23:0]        o_frame_counter,
    output logic signed [31:0] o_first_frame_coord,
    output logic               o_position_advanced,
    output logic               o_source_active
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 1);
    localparam logic [ssfd_pkg::RUN_W-1:0] RUN_LAST = ssfd_pkg::RUN_W'(ssfd_pkg::SYNC_LEN - 1);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] v);
        return (v == IDX_LAST) ? '0 : v + 1'b1;
    endfunction

    logic [7:0]                   r_window [FRAME_BYTES];
    logic [7:0]                   r_rd_data;
    logic [IDX_W-1:0]             r_fill;
    logic [IDX_W-1:0]             r_rd_addr;
    logic [ssfd_pkg::RUN_W-1:0]   r_run;
    logic                         r_found;
    logic [31:0]                  r_last_pos;
    logic                         r_active;
    logic [31:0]                  r_min_adv;
    logic                         r_out_valid;
    logic [ssfd_pkg::FIELD_W-1:0] r_field;

    logic        is_sync;
    logic [31:0] sys_coord;
    logic [31:0] coord_diff;
    logic        advance;

    // window memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_window[r_fill] <= i_rx_byte;
        end
        r_rd_data <= r_window[r_rd_addr];
    end

    assign is_sync = (r_rd_data == ssfd_pkg::SYNC_BYTE);

    // position advance test on the decoded system coordinate
    assign sys_coord  = r_field[(ssfd_pkg::OFS_SYSTEM - ssfd_pkg::FIELD_FIRST) * 8 +: 32];
    assign coord_diff = sys_coord - r_last_pos;
    assign advance    = r_found && (coord_diff > r_min_adv);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_addr   <= '0;
            r_run       <= '0;
            r_found     <= 1'b0;
            r_last_pos  <= '0;
            r_active    <= 1'b0;
            r_min_adv   <= ssfd_pkg::MIN_ADVANCE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_adv <= i_cfg_wdata;
            end
            if (i_cmd.wr_byte) begin
                r_fill <= idx_inc(r_fill);
            end
            // read pointer walks positions 1, 2, ... of the circular block
            if (i_cmd.scan_clear) begin
                r_rd_addr <= IDX_W'(1);
            end else if (i_cmd.rd_step) begin
                r_rd_addr <= idx_inc(r_rd_addr);
            end
            // count consecutive sync bytes
            if (i_cmd.scan_clear) begin
                r_run   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_eval) begin
                if (!is_sync) begin
                    r_run <= '0;
                end else if (r_run != RUN_LAST) begin
                    r_run <= r_run + 1'b1;
                end
                if (o_status.hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                if (advance) begin
                    r_last_pos <= sys_coord;
                end
                r_active <= r_active | r_found;
            end
            // result register: load wins over a transfer
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // mirrored bytes from offset 5 upward shift in from the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.field_shift) begin
            r_field <= {ssfd_pkg::mirror8(r_rd_data), r_field[ssfd_pkg::FIELD_W-1:8]};
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_sync_found        <= r_found;
            o_position_advanced <= advance;
            o_source_active     <= r_active | r_found;
            if (r_found) begin
                o_frame_flags_a <=
                    r_field[(ssfd_pkg::OFS_FLAGS_A - ssfd_pkg::FIELD_FIRST) * 8 +: 8];
                o_velocity <= $signed(
                    r_field[(ssfd_pkg::OFS_VELOCITY - ssfd_pkg::FIELD_FIRST) * 8 +: 16]);
                o_current_coord <= $signed(
                    r_field[(ssfd_pkg::OFS_CURRENT - ssfd_pkg::FIELD_FIRST) * 8 +: 32]);
                o_system_coord <= $signed(sys_coord);
                o_frame_flags_b <=
                    r_field[(ssfd_pkg::OFS_FLAGS_B - ssfd_pkg::FIELD_FIRST) * 8 +: 8];
                o_frame_counter <=
                    r_field[(ssfd_pkg::OFS_COUNTER - ssfd_pkg::FIELD_FIRST) * 8 +: 24];
                o_first_frame_coord <= $signed(
                    r_field[(ssfd_pkg::OFS_FIRST - ssfd_pkg::FIELD_FIRST) * 8 +: 32]);
            end else begin
                o_frame_flags_a     <= '0;
                o_velocity          <= '0;
                o_current_coord     <= '0;
                o_system_coord      <= '0;
                o_frame_flags_b     <= '0;
                o_frame_counter     <= '0;
                o_first_frame_coord <= '0;
            end
        end
    end

    // status to the controller
    always_comb begin
        o_status.fill_last = (r_fill == IDX_LAST);
        o_status.hit       = is_sync && (r_run == RUN_LAST);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;

    // checks
    `SSFD_ASSERT_NXT(a_fill_hold, !i_cmd.wr_byte, $stable(r_fill), "write pointer moved without a byte")
    `SSFD_ASSERT_NXT(a_nosync_result, i_cmd.out_load && !r_found, !o_position_advanced && o_source_active == $past(r_active), "result without sync changed position state")
    `SSFD_ASSERT_NXT(a_sync_active, i_cmd.out_load && r_found, o_source_active && r_active, "sync block did not set the active flag")
    `SSFD_ASSERT_IMP(a_adv_tracks, r_out_valid && o_position_advanced, r_last_pos == o_system_coord, "last position differs from advanced coordinate")

endmodule

/* rtl/sync_search_frame_decoder_top.sv */
// Sync search frame decoder: takes one byte per cycle until a FRAME_BYTES block is full.
// After the last byte the controller scans the window memory one byte a cycle for the
// sync run, then, on a hit, shifts the 19 bytes after it into the field register; the
// result is loaded once the output register is free. Input stalls from the last byte
// until the result is loaded.
// Synchronous active-low reset clears fill count, position and active flag; threshold to 200.
module sync_search_frame_decoder_top #(
    parameter int FRAME_BYTES = ssfd_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssfd_in_if.sink     i_in,
    ssfd_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    ssfd_pkg::t_cmd    cmd;
    ssfd_pkg::t_status status;

    // sequencing
    ssfd_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // storage, detection and decoding
    ssfd_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_rx_byte           (i_in.rx_byte),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_out_ready         (o_out.ready),
        .o_out_valid         (o_out.valid),
        .o_sync_found        (o_out.sync_found),
        .o_frame_flags_a     (o_out.frame_flags_a),
        .o_velocity          (o_out.velocity),
        .o_current_coord     (o_out.current_coord),
        .o_system_coord      (o_out.system_coord),
        .o_frame_flags_b     (o_out.frame_flags_b),
        .o_frame_counter     (o_out.frame_counter),
        .o_first_frame_coord (o_out.first_frame_coord),
        .o_position_advanced (o_out.position_advanced),
        .o_source_active     (o_out.source_active)
    );

endmodule
